>>> design/tsst_pkg.sv
// Shared types and constants for the section table tracker.
package tsst_pkg;

  localparam int unsigned CNT_W = 9;
  localparam int unsigned HDR_W = 13;
  localparam int unsigned CRC_W = 32;

  typedef enum logic [2:0] {
    STAT_IGNORE  = 3'd0,
    STAT_INITIAL = 3'd1,
    STAT_CHANGE  = 3'd2,
    STAT_PRESENT = 3'd3,
    STAT_APPEND  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_CRC
  } state_e;

  typedef enum logic {
    CMP_HDR,
    CMP_CRC
  } cmp_sel_e;

  typedef struct packed {
    logic [4:0]  table_version;
    logic [7:0]  section_index;
    logic [7:0]  final_index;
    logic [31:0] section_crc;
  } in_item_t;

  typedef struct packed {
    status_e status;
    logic    complete;
  } out_item_t;

  typedef struct packed {
    cmp_sel_e         sel;
    logic [HDR_W-1:0] hdr_a;
    logic [HDR_W-1:0] hdr_b;
    logic [CRC_W-1:0] crc_a;
    logic [CRC_W-1:0] crc_b;
  } cmp_req_t;

endpackage

>>> design/tsst_cmp_unit.sv
// Shared equality unit: compares either the header pair or the CRC pair.
module tsst_cmp_unit (
  input  tsst_pkg::cmp_req_t req_i,
  output logic               eq_o
);
  import tsst_pkg::*;

  logic [CRC_W-1:0] op_a;
  logic [CRC_W-1:0] op_b;

  always_comb begin
    unique case (req_i.sel)
      CMP_HDR: begin
        op_a = {{(CRC_W-HDR_W){1'b0}}, req_i.hdr_a};
        op_b = {{(CRC_W-HDR_W){1'b0}}, req_i.hdr_b};
      end
      CMP_CRC: begin
        op_a = req_i.crc_a;
        op_b = req_i.crc_b;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign eq_o = (op_a == op_b);

endmodule

>>> design/tsst_crc_store.sv
// CRC store: one write port and one registered read port.
module tsst_crc_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tsst_pkg::CRC_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tsst_pkg::CRC_W-1:0] rdata_o
);
  import tsst_pkg::*;

  logic [CRC_W-1:0] mem [DEPTH];
  logic [CRC_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ts_section_table_tracker.sv
// Top level of the section table tracker: sequencer, flags and held table.
//
// Usage: one section header request enters on the input channel (in_valid_i,
// in_stall_o, in_item_i); one result request (status, complete) leaves on
// the output channel (out_valid_o, out_stall_i, out_item_o) for each.
// A request is taken when valid is high and stall is low at a clock edge.
// Each header passes through the states in order: the accept cycle (S_IDLE)
// reads the CRC store, S_HDR compares version and last section number on the
// shared compare unit, S_CRC compares the stored CRC on the same unit, updates
// the table and loads the output register. in_stall_o is high after an accept
// until that final step is done, so a new header is taken only once the last
// one is through; the result is then held in the output register.
// While out_stall_i holds a waiting result, the next header may still be
// taken, but its final step waits until the output register is free.
// Reset clears the held table, all present flags and the section count at
// once; the CRC store needs no clearing, as an entry is used only while its
// present flag is set.
module ts_section_table_tracker #(
  parameter int unsigned MAX_SECTIONS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tsst_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsst_pkg::out_item_t out_item_o
);
  import tsst_pkg::*;

  localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam logic [CNT_W-1:0] MAX_L = CNT_W'(MAX_SECTIONS);

  state_e state_q, state_d;

  logic             in_fire;
  logic             out_fire;
  logic             step_done;
  logic             mem_re;
  cmp_sel_e         cmp_sel;
  cmp_req_t         cmp_req;
  logic             cmp_eq;

  logic [4:0]       ver_q;
  logic [7:0]       idx_q;
  logic [7:0]       fin_q;
  logic [CRC_W-1:0] crc_q;
  logic             ignore_q;
  logic             hdr_eq_q;
  logic [CRC_W-1:0] crc_rd;

  logic                    table_valid_q, table_valid_d;
  logic [4:0]              held_ver_q, held_ver_d;
  logic [7:0]              held_fin_q, held_fin_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [MAX_SECTIONS-1:0] flags_q, flags_d;

  logic      out_valid_q;
  out_item_t out_q;
  status_e   status;
  logic      complete;
  logic      do_start;
  logic      do_append;
  logic      flag_hit;
  logic      in_ignore;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  assign in_ignore = (in_item_i.section_index > in_item_i.final_index) ||
                     ({1'b0, in_item_i.final_index} >= MAX_L);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_HDR;
      S_HDR:  state_d = S_CRC;
      S_CRC:  if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    mem_re     = 1'b0;
    cmp_sel    = CMP_HDR;
    step_done  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        mem_re     = in_valid_i;
      end
      S_HDR: begin
        cmp_sel = CMP_HDR;
      end
      S_CRC: begin
        cmp_sel   = CMP_CRC;
        step_done = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ver_q    <= in_item_i.table_version;
      idx_q    <= in_item_i.section_index;
      fin_q    <= in_item_i.final_index;
      crc_q    <= in_item_i.section_crc;
      ignore_q <= in_ignore;
    end
    if (state_q == S_HDR) begin
      hdr_eq_q <= cmp_eq;
    end
  end

  assign cmp_req.sel   = cmp_sel;
  assign cmp_req.hdr_a = {ver_q, fin_q};
  assign cmp_req.hdr_b = {held_ver_q, held_fin_q};
  assign cmp_req.crc_a = crc_rd;
  assign cmp_req.crc_b = crc_q;

  tsst_cmp_unit u_cmp (
    .req_i (cmp_req),
    .eq_o  (cmp_eq)
  );

  tsst_crc_store #(
    .DEPTH (MAX_SECTIONS),
    .AW    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (step_done && (do_start || do_append)),
    .waddr_i (idx_q[IDX_W-1:0]),
    .wdata_i (crc_q),
    .re_i    (mem_re),
    .raddr_i (in_item_i.section_index[IDX_W-1:0]),
    .rdata_o (crc_rd)
  );

  assign flag_hit = flags_q[idx_q[IDX_W-1:0]];

  // Classify and update the held table
  always_comb begin
    status        = STAT_IGNORE;
    do_start      = 1'b0;
    do_append     = 1'b0;
    table_valid_d = table_valid_q;
    held_ver_d    = held_ver_q;
    held_fin_d    = held_fin_q;
    count_d       = count_q;
    flags_d       = flags_q;
    priority if (ignore_q) begin
      status = STAT_IGNORE;
    end else if (!table_valid_q) begin
      status   = STAT_INITIAL;
      do_start = 1'b1;
    end else if (!hdr_eq_q || (flag_hit && !cmp_eq)) begin
      status   = STAT_CHANGE;
      do_start = 1'b1;
    end else if (flag_hit) begin
      status = STAT_PRESENT;
    end else begin
      status    = STAT_APPEND;
      do_append = 1'b1;
    end
    if (do_start) begin
      table_valid_d                = 1'b1;
      held_ver_d                   = ver_q;
      held_fin_d                   = fin_q;
      count_d                      = CNT_W'(1);
      flags_d                      = '0;
      flags_d[idx_q[IDX_W-1:0]]    = 1'b1;
    end else if (do_append) begin
      count_d                      = count_q + CNT_W'(1);
      flags_d[idx_q[IDX_W-1:0]]    = 1'b1;
    end
    complete = table_valid_d && (count_d == ({1'b0, held_fin_d} + CNT_W'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_valid_q <= 1'b0;
      held_ver_q    <= '0;
      held_fin_q    <= '0;
      count_q       <= '0;
      flags_q       <= '0;
    end else if (step_done) begin
      table_valid_q <= table_valid_d;
      held_ver_q    <= held_ver_d;
      held_fin_q    <= held_fin_d;
      count_q       <= count_d;
      flags_q       <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_done) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_done) begin
      out_q.status   <= status;
      out_q.complete <= complete;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("header accepted while previous one still in work");

  a_count_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(flags_q) == int'(count_q))
    else $error("section count disagrees with present flags");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    table_valid_q |-> (count_q <= ({1'b0, held_fin_q} + CNT_W'(1))))
    else $error("section count exceeds table length");

  a_empty_when_no_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !table_valid_q |-> (count_q == '0))
    else $error("sections counted with no table held");

endmodule

>>> tb/ts_section_table_tracker_tb.sv
// Self-checking testbench for the section table tracker with its own table predictor.
`timescale 1ns / 1ps

module ts_section_table_tracker_tb;
  import tsst_pkg::*;

  localparam int unsigned SECTION_TARGET = 1050;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  bit          tbl_held;
  bit [4:0]    tbl_version;
  bit [7:0]    tbl_final;
  bit          sec_present [256];
  bit [31:0]   sec_crc [256];
  bit [8:0]    sec_count;

  out_item_t   expected_results [$];
  int unsigned sections_sent;
  int unsigned idle_pct  = 36;
  int unsigned stall_pct = 36;
  int unsigned err_cnt;
  int unsigned result_cnt;
  int unsigned ignore_cnt;
  int unsigned change_cnt;
  int unsigned tables_done;
  int unsigned cycle_cnt;

  ts_section_table_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt   <= cycle_cnt + 1;
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("%0t: timeout, %0d results still awaited", $time, expected_results.size());
    $display("ts_section_table_tracker_tb: errors");
    $finish;
  end

  function automatic in_item_t mk_section(input logic [4:0] ver, input logic [7:0] idx,
                                          input logic [7:0] fin, input logic [31:0] crc);
    in_item_t it;
    it.table_version = ver;
    it.section_index = idx;
    it.final_index   = fin;
    it.section_crc   = crc;
    return it;
  endfunction

  function automatic void restart_table(input in_item_t it);
    foreach (sec_present[i]) sec_present[i] = 1'b0;
    tbl_held                     = 1'b1;
    tbl_version                  = it.table_version;
    tbl_final                    = it.final_index;
    sec_present[it.section_index] = 1'b1;
    sec_crc[it.section_index]     = it.section_crc;
    sec_count                    = 9'd1;
  endfunction

  function automatic out_item_t classify_section(input in_item_t it);
    out_item_t res;
    if (it.section_index > it.final_index) begin
      res.status = STAT_IGNORE;
    end else if (!tbl_held) begin
      restart_table(it);
      res.status = STAT_INITIAL;
    end else if (tbl_version != it.table_version || tbl_final != it.final_index ||
                 (sec_present[it.section_index] &&
                  sec_crc[it.section_index] != it.section_crc)) begin
      restart_table(it);
      res.status = STAT_CHANGE;
    end else if (sec_present[it.section_index]) begin
      res.status = STAT_PRESENT;
    end else begin
      sec_present[it.section_index] = 1'b1;
      sec_crc[it.section_index]     = it.section_crc;
      sec_count                     = sec_count + 9'd1;
      res.status = STAT_APPEND;
    end
    res.complete = tbl_held && (sec_count == {1'b0, tbl_final} + 9'd1);
    return res;
  endfunction

  task automatic send_section(input in_item_t it);
    out_item_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = classify_section(it);
    expected_results.push_back(want);
    if (want.status != STAT_IGNORE) sections_sent++;
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (expected_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, got status %0d complete %0b",
                 $time, out_item_o.status, out_item_o.complete);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.status !== want.status) begin
          err_cnt++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_item_o.status);
        end
        if (out_item_o.complete !== want.complete) begin
          err_cnt++;
          $display("%0t: complete mismatch, expected %0b, got %0b",
                   $time, want.complete, out_item_o.complete);
        end
        if (want.status == STAT_IGNORE) ignore_cnt++;
        if (want.status == STAT_CHANGE) change_cnt++;
        if (want.complete && (want.status == STAT_APPEND || want.status == STAT_INITIAL ||
                              want.status == STAT_CHANGE)) tables_done++;
      end
    end
  end

  task automatic test_directed();
    send_section(mk_section(5'd0, 8'd1, 8'd0, 32'h0000_0000));
    send_section(mk_section(5'd31, 8'd0, 8'd0, 32'hFFFF_FFFF));
    send_section(mk_section(5'd31, 8'd0, 8'd0, 32'hFFFF_FFFF));
    send_section(mk_section(5'd31, 8'd255, 8'd254, 32'h0000_0000));
    send_section(mk_section(5'd31, 8'd0, 8'd0, 32'h0000_0000));
    send_section(mk_section(5'd31, 8'd0, 8'd2, 32'h0000_0000));
    send_section(mk_section(5'd30, 8'd1, 8'd2, 32'hAAAA_AAAA));
    send_section(mk_section(5'd30, 8'd0, 8'd2, 32'h5555_5555));
    send_section(mk_section(5'd30, 8'd2, 8'd2, 32'h1234_5678));
    send_section(mk_section(5'd30, 8'd2, 8'd2, 32'h1234_5678));
    send_section(mk_section(5'd30, 8'd3, 8'd2, 32'h0000_0000));
    send_section(mk_section(5'd30, 8'd1, 8'd2, 32'hAAAA_AAAB));
    send_section(mk_section(5'h15, 8'd255, 8'd255, 32'hAAAA_AAAA));
    send_section(mk_section(5'h15, 8'd0, 8'd255, 32'h5555_5555));
    send_section(mk_section(5'h15, 8'hAA, 8'd255, 32'h0000_0000));
    send_section(mk_section(5'h15, 8'h55, 8'd255, 32'hFFFF_FFFF));
    send_section(mk_section(5'h0A, 8'd0, 8'd0, 32'h0000_0000));
    send_section(mk_section(5'h0A, 8'd0, 8'd0, 32'h0000_0000));
  endtask

  task automatic test_full_table();
    logic [4:0]  ver;
    logic [31:0] crc_of [256];
    int unsigned order [256];
    int unsigned n, j, tmp;
    idle_pct  = 0;
    stall_pct = 0;
    ver = 5'($urandom);
    for (n = 0; n < 256; n++) begin
      order[n]  = n;
      crc_of[n] = $urandom;
    end
    for (n = 255; n > 0; n--) begin
      j = $urandom_range(n);
      tmp = order[n]; order[n] = order[j]; order[j] = tmp;
    end
    for (n = 0; n < 256; n++) begin
      send_section(mk_section(ver, 8'(order[n]), 8'd255, crc_of[order[n]]));
      if ($urandom_range(99) < 10) begin
        j = order[$urandom_range(n)];
        send_section(mk_section(ver, 8'(j), 8'd255, crc_of[j]));
      end
    end
    idle_pct  = 36;
    stall_pct = 36;
  endtask

  task automatic test_random_tables();
    logic [4:0]  ver;
    logic [7:0]  fin;
    logic [7:0]  alt_fin;
    logic [31:0] crc_of [256];
    int unsigned order [256];
    int unsigned n, j, tmp, roll;
    bit          broken;
    while (sections_sent < SECTION_TARGET) begin
      ver  = 5'($urandom);
      roll = $urandom_range(99);
      if (roll < 80)      fin = 8'($urandom_range(7));
      else if (roll < 98) fin = 8'($urandom_range(40, 8));
      else                fin = 8'($urandom_range(100, 41));
      for (n = 0; n <= 32'(fin); n++) begin
        order[n]  = n;
        crc_of[n] = $urandom;
      end
      for (n = 32'(fin); n > 0; n--) begin
        j = $urandom_range(n);
        tmp = order[n]; order[n] = order[j]; order[j] = tmp;
      end
      broken = 1'b0;
      for (n = 0; n <= 32'(fin) && !broken; n++) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          if ($urandom_range(1)) begin
            send_section(mk_section(ver, 8'($urandom_range(255, 32'(fin) + 1)), fin,
                                    $urandom));
          end else begin
            send_section(mk_section(5'($urandom), 8'($urandom), 8'($urandom), $urandom));
          end
        end
        if (roll >= 5 && roll < 9) begin
          broken = 1'b1;
          case ($urandom_range(2))
            0: begin
              send_section(mk_section(ver + 5'($urandom_range(31, 1)), 8'(order[n]), fin,
                                      crc_of[order[n]]));
            end
            1: begin
              alt_fin = fin ^ 8'($urandom_range(255, 1));
              send_section(mk_section(ver, 8'($urandom_range(32'(alt_fin))), alt_fin,
                                      $urandom));
            end
            default: begin
              j = order[$urandom_range(n)];
              send_section(mk_section(ver, 8'(j), fin,
                                      crc_of[j] ^ 32'($urandom_range(255, 1))));
            end
          endcase
        end else begin
          send_section(mk_section(ver, 8'(order[n]), fin, crc_of[order[n]]));
          if ($urandom_range(99) < 15) begin
            j = order[$urandom_range(n)];
            send_section(mk_section(ver, 8'(j), fin, crc_of[j]));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random_tables();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d results: %0d ignored, %0d table restarts, %0d tables completed.",
             result_cnt, ignore_cnt, change_cnt, tables_done);
    $display("Included a full 256-section table without gaps or stalls; %0d mismatches.",
             err_cnt);
    if (err_cnt == 0) begin
      $display("ts_section_table_tracker_tb: clean");
    end else begin
      $display("ts_section_table_tracker_tb: errors");
    end
    $finish;
  end

endmodule

>>> ts_section_table_tracker.f
design/tsst_pkg.sv
design/tsst_cmp_unit.sv
design/tsst_crc_store.sv
design/ts_section_table_tracker.sv
tb/ts_section_table_tracker_tb.sv
